[src/ate_pkg.sv]
// Package for the array table engine: action and status codes, widths and the sequencer states.
// It has no dependencies. The top level array_table_engine imports it.
`default_nettype none
package ate_pkg;

    localparam int VAL_W = 32;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;

    typedef enum logic [3:0] {
        ACT_CLEAR  = 4'd0,
        ACT_APPEND = 4'd1,
        ACT_LIST   = 4'd2,
        ACT_MAX    = 4'd3,
        ACT_PRIMES = 4'd4,
        ACT_INSERT = 4'd5,
        ACT_DELETE = 4'd6,
        ACT_SORT   = 4'd7,
        ACT_SEARCH = 4'd8
    } action_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BAD   = 2'd1,
        ST_NONE  = 2'd2,
        ST_EMPTY = 2'd3
    } status_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_EMIT,
        S_INS_RD,
        S_INS_WR,
        S_LIST_RD,
        S_LIST_GET,
        S_MAX_RD,
        S_MAX_CMP,
        S_PR_RD,
        S_PR_LOAD,
        S_PR_CHK,
        S_PR_DIV,
        S_PR_DCHK,
        S_PR_NEXT,
        S_DEL_RD,
        S_DEL_GET,
        S_DEL_RD2,
        S_DEL_WR,
        S_SO_KEY,
        S_SO_KEYGET,
        S_SO_CMP_RD,
        S_SO_CMP,
        S_SE_RD,
        S_SE_CMP
    } state_t;

endpackage
`default_nettype wire

[src/array_table_engine.sv]
// Top level of the array table engine: an ordered table of signed values with a small sequencer.
// It depends on ate_pkg and holds the table memory, the subtract unit of the prime test and the
// output register.
//
//   Channel   Direction  Beat contents
//   s_axis    in         tdata: data_value, position; tuser: action
//   m_axis    out        tdata: result_value, result_index; tuser: status; tlast: last_result
//
// One item is taken at a time; s_axis_tready is high only while the sequencer is idle.
// Append, insert and delete shift entries one at a time, max, search and list walk the table once,
// and sort is an insertion sort that moves each key down entry by entry.
// Each trial divisor of the prime test goes through the bit-serial remainder unit.
// A stalled m_axis holds the sequencer at its next result. Reset empties the table at once.
`default_nettype none
module array_table_engine #(
    parameter int CAPACITY = 64
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,  // data_value[31:0], position[39:32]
    input  wire logic [3:0]  s_axis_tuser,  // action[3:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // result_value[31:0], result_index[37:32], zeros
    output logic [1:0]       m_axis_tuser,  // status[1:0]
    output logic             m_axis_tlast   // last_result
);
    import ate_pkg::*;

    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic signed [VAL_W-1:0] mem [CAPACITY];
    logic signed [VAL_W-1:0] rdata_reg;
    logic [IDX_W-1:0]        rd_addr;
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic signed [VAL_W-1:0] wdata;

    state_t state_reg, state_next, ret_reg, ret_next;
    logic [3:0]              act_reg, act_next;
    logic signed [VAL_W-1:0] val_reg, val_next;
    logic [7:0]              pos_reg, pos_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic [CNT_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic signed [VAL_W-1:0] wv_reg, wv_next;
    logic signed [VAL_W-1:0] hv_reg, hv_next;
    logic [IDX_W-1:0]        hi_reg, hi_next;
    logic                    have_reg, have_next;
    logic [16:0]             d_reg, d_next;
    logic [32:0]             dsq_reg, dsq_next;
    logic [VAL_W-1:0]        rem_reg, rem_next;
    logic [VAL_W-1:0]        dvd_reg, dvd_next;
    logic [5:0]              bit_reg, bit_next;
    logic signed [VAL_W-1:0] pv_reg, pv_next;
    logic [IDX_W-1:0]        pi_reg, pi_next;
    logic [1:0]              ps_reg, ps_next;
    logic                    pl_reg, pl_next;
    logic                    ov_reg, ov_next;
    logic signed [VAL_W-1:0] ovl_reg, ovl_next;
    logic [IDX_W-1:0]        oix_reg, oix_next;
    logic [1:0]              ost_reg, ost_next;
    logic                    olast_reg, olast_next;

    logic             out_free;
    logic             i_last;
    logic [VAL_W:0]   rem_sh;
    logic [VAL_W:0]   rem_sub;

    assign out_free      = !ov_reg || m_axis_tready;
    assign i_last        = (i_reg + CNT_W'(1)) == cnt_reg;
    assign rem_sh        = {rem_reg, dvd_reg[VAL_W-1]};
    assign rem_sub       = rem_sh - {16'd0, d_reg};
    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {2'b00, oix_reg, ovl_reg};
    assign m_axis_tuser  = ost_reg;
    assign m_axis_tlast  = olast_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            cnt_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        val_reg   <= val_next;
        pos_reg   <= pos_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
        wv_reg    <= wv_next;
        hv_reg    <= hv_next;
        hi_reg    <= hi_next;
        have_reg  <= have_next;
        d_reg     <= d_next;
        dsq_reg   <= dsq_next;
        rem_reg   <= rem_next;
        dvd_reg   <= dvd_next;
        bit_reg   <= bit_next;
        pv_reg    <= pv_next;
        pi_reg    <= pi_next;
        ps_reg    <= ps_next;
        pl_reg    <= pl_next;
        ovl_reg   <= ovl_next;
        oix_reg   <= oix_next;
        ost_reg   <= ost_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        act_next   = act_reg;
        val_next   = val_reg;
        pos_next   = pos_reg;
        cnt_next   = cnt_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        wv_next    = wv_reg;
        hv_next    = hv_reg;
        hi_next    = hi_reg;
        have_next  = have_reg;
        d_next     = d_reg;
        dsq_next   = dsq_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        bit_next   = bit_reg;
        pv_next    = pv_reg;
        pi_next    = pi_reg;
        ps_next    = ps_reg;
        pl_next    = pl_reg;
        ov_next    = ov_reg && !m_axis_tready;
        ovl_next   = ovl_reg;
        oix_next   = oix_reg;
        ost_next   = ost_reg;
        olast_next = olast_reg;
        rd_addr    = i_reg[IDX_W-1:0];
        we         = 1'b0;
        waddr      = i_reg[IDX_W-1:0];
        wdata      = rdata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    act_next   = s_axis_tuser;
                    val_next   = s_axis_tdata[31:0];
                    pos_next   = s_axis_tdata[39:32];
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                pv_next    = '0;
                pi_next    = '0;
                ps_next    = ST_OK;
                pl_next    = 1'b1;
                ret_next   = S_IDLE;
                state_next = S_EMIT;
                i_next     = '0;
                have_next  = 1'b0;
                if (act_reg > ACT_SEARCH)
                begin
                    state_next = S_IDLE;
                end
                else if (act_reg == ACT_CLEAR)
                begin
                    cnt_next = '0;
                end
                else if (act_reg == ACT_APPEND || act_reg == ACT_INSERT)
                begin
                    if (act_reg == ACT_APPEND)
                    begin
                        pos_next = {1'b0, cnt_reg};
                    end
                    if (cnt_reg >= CAP ||
                        (act_reg == ACT_INSERT && pos_reg > {1'b0, cnt_reg}))
                    begin
                        ps_next = ST_BAD;
                    end
                    else
                    begin
                        i_next     = cnt_reg;
                        state_next = S_INS_RD;
                    end
                end
                else if (cnt_reg == '0)
                begin
                    ps_next = ST_EMPTY;
                end
                else
                begin
                    unique case (act_reg)
                        ACT_LIST:   state_next = S_LIST_RD;
                        ACT_MAX:    state_next = S_MAX_RD;
                        ACT_PRIMES: state_next = S_PR_RD;
                        ACT_DELETE:
                        begin
                            if (pos_reg >= {1'b0, cnt_reg})
                            begin
                                ps_next = ST_BAD;
                            end
                            else
                            begin
                                i_next     = pos_reg[CNT_W-1:0];
                                state_next = S_DEL_RD;
                            end
                        end
                        ACT_SORT:
                        begin
                            i_next     = CNT_W'(1);
                            state_next = S_SO_KEY;
                        end
                        default:    state_next = S_SE_RD;
                    endcase
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ovl_next   = pv_reg;
                    oix_next   = pi_reg;
                    ost_next   = ps_reg;
                    olast_next = pl_reg;
                    state_next = ret_reg;
                end
            end
            S_INS_RD:
            begin
                rd_addr = i_reg[IDX_W-1:0] - IDX_W'(1);
                if (i_reg > {1'b0, pos_reg[CNT_W-2:0]} || pos_reg[7:CNT_W-1] != '0)
                begin
                    state_next = S_INS_WR;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = pos_reg[IDX_W-1:0];
                    wdata      = val_reg;
                    cnt_next   = cnt_reg + CNT_W'(1);
                    pv_next    = val_reg;
                    pi_next    = pos_reg[IDX_W-1:0];
                    ps_next    = ST_OK;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_INS_WR:
            begin
                we         = 1'b1;
                i_next     = i_reg - CNT_W'(1);
                state_next = S_INS_RD;
            end
            S_LIST_RD:
            begin
                state_next = S_LIST_GET;
            end
            S_LIST_GET:
            begin
                pv_next    = rdata_reg;
                pi_next    = i_reg[IDX_W-1:0];
                ps_next    = ST_OK;
                pl_next    = i_last;
                i_next     = i_reg + CNT_W'(1);
                ret_next   = i_last ? S_IDLE : S_LIST_RD;
                state_next = S_EMIT;
            end
            S_MAX_RD:
            begin
                state_next = S_MAX_CMP;
            end
            S_MAX_CMP:
            begin
                if (i_reg == '0 || rdata_reg > wv_reg)
                begin
                    wv_next = rdata_reg;
                    hi_next = i_reg[IDX_W-1:0];
                end
                if (i_last)
                begin
                    pv_next    = (i_reg == '0 || rdata_reg > wv_reg) ? rdata_reg : wv_reg;
                    pi_next    = (i_reg == '0 || rdata_reg > wv_reg) ? i_reg[IDX_W-1:0]
                                                                    : hi_reg;
                    ps_next    = ST_OK;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_MAX_RD;
                end
            end
            S_PR_RD:
            begin
                state_next = S_PR_LOAD;
            end
            S_PR_LOAD:
            begin
                wv_next  = rdata_reg;
                d_next   = 17'd2;
                dsq_next = 33'd4;
                if (rdata_reg <= 32'sd1)
                begin
                    state_next = S_PR_NEXT;
                end
                else
                begin
                    state_next = S_PR_CHK;
                end
            end
            S_PR_CHK:
            begin
                if (dsq_reg > {1'b0, wv_reg})
                begin
                    hv_next   = wv_reg;
                    hi_next   = i_reg[IDX_W-1:0];
                    have_next = 1'b1;
                    if (have_reg)
                    begin
                        pv_next    = hv_reg;
                        pi_next    = hi_reg;
                        ps_next    = ST_OK;
                        pl_next    = 1'b0;
                        ret_next   = S_PR_NEXT;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_PR_NEXT;
                    end
                end
                else
                begin
                    rem_next   = '0;
                    dvd_next   = wv_reg;
                    bit_next   = 6'd32;
                    state_next = S_PR_DIV;
                end
            end
            S_PR_DIV:
            begin
                dvd_next = {dvd_reg[VAL_W-2:0], 1'b0};
                rem_next = rem_sub[VAL_W] ? rem_sh[VAL_W-1:0] : rem_sub[VAL_W-1:0];
                bit_next = bit_reg - 6'd1;
                if (bit_reg == 6'd1)
                begin
                    state_next = S_PR_DCHK;
                end
            end
            S_PR_DCHK:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_PR_NEXT;
                end
                else
                begin
                    d_next     = d_reg + 17'd1;
                    dsq_next   = dsq_reg + {15'd0, d_reg, 1'b1};
                    state_next = S_PR_CHK;
                end
            end
            S_PR_NEXT:
            begin
                if (i_last)
                begin
                    pv_next    = have_reg ? hv_reg : '0;
                    pi_next    = have_reg ? hi_reg : '0;
                    ps_next    = have_reg ? ST_OK : ST_NONE;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_PR_RD;
                end
            end
            S_DEL_RD:
            begin
                state_next = S_DEL_GET;
            end
            S_DEL_GET:
            begin
                hv_next    = rdata_reg;
                state_next = S_DEL_RD2;
            end
            S_DEL_RD2:
            begin
                rd_addr = i_reg[IDX_W-1:0] + IDX_W'(1);
                if (!i_last)
                begin
                    state_next = S_DEL_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CNT_W'(1);
                    pv_next    = hv_reg;
                    pi_next    = pos_reg[IDX_W-1:0];
                    ps_next    = ST_OK;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
            end
            S_DEL_WR:
            begin
                we         = 1'b1;
                i_next     = i_reg + CNT_W'(1);
                state_next = S_DEL_RD2;
            end
            S_SO_KEY:
            begin
                if (i_reg >= cnt_reg)
                begin
                    pv_next    = '0;
                    pi_next    = '0;
                    ps_next    = ST_OK;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    state_next = S_SO_KEYGET;
                end
            end
            S_SO_KEYGET:
            begin
                wv_next    = rdata_reg;
                j_next     = i_reg[IDX_W-1:0];
                state_next = S_SO_CMP_RD;
            end
            S_SO_CMP_RD:
            begin
                rd_addr = j_reg - IDX_W'(1);
                if (j_reg != '0)
                begin
                    state_next = S_SO_CMP;
                end
                else
                begin
                    we         = 1'b1;
                    waddr      = '0;
                    wdata      = wv_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SO_KEY;
                end
            end
            S_SO_CMP:
            begin
                we    = 1'b1;
                waddr = j_reg;
                if (rdata_reg > wv_reg)
                begin
                    j_next     = j_reg - IDX_W'(1);
                    state_next = S_SO_CMP_RD;
                end
                else
                begin
                    wdata      = wv_reg;
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SO_KEY;
                end
            end
            S_SE_RD:
            begin
                state_next = S_SE_CMP;
            end
            S_SE_CMP:
            begin
                if (rdata_reg == val_reg)
                begin
                    pv_next    = val_reg;
                    pi_next    = i_reg[IDX_W-1:0];
                    ps_next    = ST_OK;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else if (i_last)
                begin
                    pv_next    = '0;
                    pi_next    = '0;
                    ps_next    = ST_NONE;
                    pl_next    = 1'b1;
                    ret_next   = S_IDLE;
                    state_next = S_EMIT;
                end
                else
                begin
                    i_next     = i_reg + CNT_W'(1);
                    state_next = S_SE_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

[tb/sv/array_table_checker.sv]
// Result checker for the array table engine: watches both stream channels, predicts every result.
// It depends on ate_pkg and reports a mismatch count and the number of results still awaited.
`default_nettype none
module array_table_checker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    input  wire logic        s_axis_tready,
    input  wire logic [39:0] s_axis_tdata,
    input  wire logic [3:0]  s_axis_tuser,
    input  wire logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    input  wire logic [39:0] m_axis_tdata,
    input  wire logic [1:0]  m_axis_tuser,
    input  wire logic        m_axis_tlast,
    output int               mismatches,
    output int               awaited
);
    import ate_pkg::*;

    localparam int CAPACITY = 64;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        index;
        status_t                 status;
        logic                    last;
    } table_result_t;

    logic signed [VAL_W-1:0] table_copy [CAPACITY];
    int                      entry_count;
    table_result_t           expected_results [$];
    int                      fail_count;

    assign mismatches = fail_count;
    assign awaited    = expected_results.size();

    function automatic bit trial_prime(logic signed [VAL_W-1:0] v);
        longint d;
        if (v <= 1)
            return 0;
        for (d = 2; d * d <= longint'(v); d++)
            if (longint'(v) % d == 0)
                return 0;
        return 1;
    endfunction

    task automatic push_result(logic signed [VAL_W-1:0] v, int idx, status_t st, bit last);
        table_result_t r;
        r.value  = v;
        r.index  = idx[IDX_W-1:0];
        r.status = st;
        r.last   = last;
        expected_results.push_back(r);
    endtask

    task automatic predict_action(logic [3:0] act, logic signed [VAL_W-1:0] val, int pos);
        int n;
        int i;
        int j;
        int k;
        int best;
        logic signed [VAL_W-1:0] key;
        n = entry_count;
        if (act > ACT_SEARCH)
            return;
        if (act == ACT_CLEAR)
        begin
            entry_count = 0;
            push_result(0, 0, ST_OK, 1);
            return;
        end
        if (act == ACT_APPEND || act == ACT_INSERT)
        begin
            if (act == ACT_APPEND)
                pos = n;
            if (n >= CAPACITY || pos > n)
            begin
                push_result(0, 0, ST_BAD, 1);
                return;
            end
            for (i = n; i > pos; i--)
                table_copy[i] = table_copy[i-1];
            table_copy[pos] = val;
            entry_count = n + 1;
            push_result(val, pos, ST_OK, 1);
            return;
        end
        if (n == 0)
        begin
            push_result(0, 0, ST_EMPTY, 1);
            return;
        end
        case (act)
            ACT_LIST:
                for (i = 0; i < n; i++)
                    push_result(table_copy[i], i, ST_OK, i + 1 == n);
            ACT_MAX:
            begin
                best = 0;
                for (i = 1; i < n; i++)
                    if (table_copy[i] > table_copy[best])
                        best = i;
                push_result(table_copy[best], best, ST_OK, 1);
            end
            ACT_PRIMES:
            begin
                k = 0;
                for (i = 0; i < n; i++)
                    if (trial_prime(table_copy[i]))
                    begin
                        push_result(table_copy[i], i, ST_OK, 0);
                        k++;
                    end
                if (k == 0)
                    push_result(0, 0, ST_NONE, 1);
                else
                    expected_results[expected_results.size()-1].last = 1;
            end
            ACT_DELETE:
            begin
                if (pos >= n)
                    push_result(0, 0, ST_BAD, 1);
                else
                begin
                    key = table_copy[pos];
                    for (i = pos; i + 1 < n; i++)
                        table_copy[i] = table_copy[i+1];
                    entry_count = n - 1;
                    push_result(key, pos, ST_OK, 1);
                end
            end
            ACT_SORT:
            begin
                for (i = 1; i < n; i++)
                begin
                    key = table_copy[i];
                    j = i;
                    while (j > 0 && table_copy[j-1] > key)
                    begin
                        table_copy[j] = table_copy[j-1];
                        j--;
                    end
                    table_copy[j] = key;
                end
                push_result(0, 0, ST_OK, 1);
            end
            default:
            begin
                k = -1;
                for (i = 0; i < n && k < 0; i++)
                    if (table_copy[i] == val)
                        k = i;
                if (k < 0)
                    push_result(0, 0, ST_NONE, 1);
                else
                    push_result(val, k, ST_OK, 1);
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        table_result_t want;
        if (!rst_n)
        begin
            entry_count = 0;
            fail_count  = 0;
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected result beat: value %0d index %0d status %0d last %0b",
                                 $signed(m_axis_tdata[31:0]), m_axis_tdata[37:32],
                                 m_axis_tuser, m_axis_tlast);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (want.value !== m_axis_tdata[31:0] || want.index !== m_axis_tdata[37:32]
                        || want.status !== m_axis_tuser || want.last !== m_axis_tlast
                        || m_axis_tdata[39:38] !== 2'b00)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected %0d/%0d/%0d/%0b, got %0d/%0d/%0d/%0b",
                                     want.value, want.index, want.status, want.last,
                                     $signed(m_axis_tdata[31:0]), m_axis_tdata[37:32],
                                     m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_action(s_axis_tuser, s_axis_tdata[31:0], int'(s_axis_tdata[39:32]));
        end
    end

endmodule
`default_nettype wire

[tb/sv/array_table_engine_tb.sv]
// Testbench top for the array table engine: clock, reset, action stimulus and the verdict.
// It depends on ate_pkg, array_table_engine and array_table_checker.
`default_nettype none
module array_table_engine_tb;
    import ate_pkg::*;

    localparam int STALL_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;  // data_value[31:0], position[39:32]
    logic [3:0]  s_axis_tuser;  // action[3:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;  // result_value[31:0], result_index[37:32], zeros
    logic [1:0]  m_axis_tuser;  // status[1:0]
    logic        m_axis_tlast;
    int          mismatches;
    int          awaited;
    int          stall_cycles;
    int          ready_hold;
    bit          gaps_on;
    int          fill;

    array_table_engine uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
    );

    array_table_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast),
        .mismatches(mismatches), .awaited(awaited)
    );

    initial
        clk = 0;
    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_axis_tready <= (ready_hold == 1);
        end
        else if (gaps_on && $urandom_range(0, 9) == 0)
        begin
            ready_hold <= $urandom_range(1, 17);
            m_axis_tready <= 0;
        end
        else
            m_axis_tready <= 1;
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Large positive values are kept even so that the serial prime test stays short.
    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        if ($urandom_range(0, 3) == 0)
        begin
            v = $urandom;
            if (!v[31])
                v[0] = 1'b0;
        end
        else
            v = $urandom_range(0, 500) - 100;
        return v;
    endfunction

    task automatic send_action(action_t act, logic [31:0] val, int pos);
        int gap;
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 17);
            s_axis_tvalid <= 0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {8'(pos), val};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        case (act)
            ACT_CLEAR:  fill = 0;
            ACT_APPEND: if (fill < 64) fill++;
            ACT_INSERT: if (fill < 64 && pos <= fill) fill++;
            ACT_DELETE: if (pos < fill) fill--;
            default: ;
        endcase
    endtask

    task automatic random_action();
        int pick;
        int p;
        pick = $urandom_range(0, 99);
        p = (fill == 0) ? 0 : $urandom_range(0, fill);
        if ($urandom_range(0, 9) == 0)
            p = $urandom_range(0, 255);
        if (pick < 30)
            send_action(ACT_APPEND, pick_value(), $urandom_range(0, 255));
        else if (pick < 45)
            send_action(ACT_INSERT, pick_value(), p);
        else if (pick < 60)
            send_action(ACT_DELETE, $urandom, (p > 0 && p == fill) ? p - 1 : p);
        else if (pick < 67)
            send_action(ACT_LIST, $urandom, $urandom_range(0, 255));
        else if (pick < 74)
            send_action(ACT_MAX, $urandom, $urandom_range(0, 255));
        else if (pick < 80)
            send_action(ACT_PRIMES, $urandom, $urandom_range(0, 255));
        else if (pick < 87)
            send_action(ACT_SORT, $urandom, $urandom_range(0, 255));
        else if (pick < 97)
            send_action(ACT_SEARCH, $urandom_range(0, 80) - 20, $urandom_range(0, 255));
        else if (pick < 98)
            send_action(ACT_CLEAR, $urandom, $urandom_range(0, 255));
        else
            send_action(action_t'($urandom_range(9, 15)), $urandom, $urandom_range(0, 255));
    endtask

    initial
    begin
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = '0;
        s_axis_tuser = ACT_CLEAR;
        m_axis_tready = 0;
        ready_hold = 0;
        stall_cycles = 0;
        gaps_on = 1;
        fill = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_action(ACT_LIST, 0, 0);
        send_action(ACT_MAX, 0, 0);
        send_action(ACT_PRIMES, 0, 0);
        send_action(ACT_DELETE, 0, 0);
        send_action(ACT_SORT, 0, 0);
        send_action(ACT_SEARCH, 0, 0);
        send_action(ACT_APPEND, 32'h8000_0000, 8'hFF);
        send_action(ACT_APPEND, 32'h7FFF_FFFE, 0);
        send_action(ACT_INSERT, 7, 0);
        send_action(ACT_INSERT, 1, 3);
        send_action(ACT_INSERT, 2, 5);
        send_action(ACT_INSERT, -1, 8'hFF);
        send_action(ACT_APPEND, 0, 0);
        send_action(ACT_LIST, 0, 0);
        send_action(ACT_MAX, 0, 0);
        send_action(ACT_PRIMES, 0, 0);
        send_action(ACT_SEARCH, 1, 0);
        send_action(ACT_SEARCH, 12345, 0);
        send_action(ACT_SORT, 0, 0);
        send_action(ACT_LIST, 0, 0);
        send_action(ACT_DELETE, 0, 8'hFF);
        send_action(ACT_DELETE, 0, 4);
        send_action(action_t'(4'hF), 0, 0);
        send_action(ACT_CLEAR, 0, 0);
        send_action(ACT_APPEND, 4, 0);
        send_action(ACT_PRIMES, 0, 0);

        for (int n = 0; n < 150; n++)
        begin
            if (n == 60)
                while (fill < 64)
                    send_action(ACT_APPEND, pick_value(), 0);
            if (n == 61)
            begin
                send_action(ACT_APPEND, 5, 0);
                send_action(ACT_INSERT, 5, 0);
                send_action(ACT_PRIMES, 0, 0);
                send_action(ACT_SORT, 0, 0);
                send_action(ACT_LIST, 0, 0);
            end
            if (n == 100)
            begin
                s_axis_tvalid <= 0;
                @(posedge clk);
                while (awaited != 0)
                    @(posedge clk);
            end
            if (n == 125)
                gaps_on = 0;
            random_action();
        end
        s_axis_tvalid <= 0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        if (mismatches == 0 && awaited == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
